[src/r3cc_pkg.sv]
// Shared types and constants for the RGB 3x3 convolution filter.
// No dependencies.
`timescale 1ns / 1ps
package r3cc_pkg;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COEF_BITS  = 16;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int DIM_BITS   = 11;
   localparam int POS_BITS   = 10;
   localparam int PIX_BITS   = 24;
   localparam int PROD_BITS  = COEF_BITS + 9;
   localparam int SUM_BITS   = PROD_BITS + 4;
   localparam int QB         = SUM_BITS;
   localparam int CYC_BITS   = $clog2(QB + 2);
   localparam logic [7:0] PIX_MAX = 8'd255;

   typedef enum logic [2:0] {
      REG_KTOP = 3'd0, REG_KMID = 3'd1, REG_KBOT = 3'd2,
      REG_DIV = 3'd3, REG_WIDTH = 3'd4, REG_HEIGHT = 3'd5
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0, ST_SUM = 2'd1, ST_DIV = 2'd2, ST_OUT = 2'd3
   } state_type;

   // top-level control: idle, window just loaded, lanes running
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0, PH_LOAD = 2'd1, PH_BUSY = 2'd2
   } phase_type;

   typedef logic signed [COEF_BITS-1:0] coef_type;
   typedef coef_type [8:0] kernel_type;

   // lane control: start strobe and lanes busy
   typedef struct packed {
      logic start;
      logic busy;
   } lane_ctl_type;
endpackage

[src/r3cc_lane.sv]
// One color lane: 3x3 multiply-accumulate, then restoring signed division
// one quotient bit per cycle, then clamp. Uses r3cc_pkg.
`timescale 1ns / 1ps
module r3cc_lane
   import r3cc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [7:0]           pix [9],
   input  kernel_type           kern,
   input  logic signed [15:0]   divisor,
   output logic                 done,
   output logic [7:0]           result
);
   logic [3:0]                  tap_ff, tap_in;
   logic signed [SUM_BITS-1:0]  acc_ff, acc_in;
   logic [QB-1:0]               quo_ff, quo_in;
   logic [QB:0]                 rem_ff, rem_in;
   logic [QB-1:0]               num_ff, num_in;
   logic [15:0]                 dmag_ff, dmag_in;
   logic                        neg_ff, neg_in;
   logic [CYC_BITS-1:0]         cnt_ff, cnt_in;
   state_type                   st_ff, st_in;
   logic [7:0]                  res_ff, res_in;
   logic signed [PROD_BITS-1:0] prod;
   logic signed [16:0]          dsx;
   logic [QB:0]                 trial;
   logic signed [QB:0]          sq;

   always_comb begin
      dsx = (divisor == 16'sd0) ? 17'sd1 : 17'(divisor);
      prod = PROD_BITS'(kern[tap_ff] * $signed({1'b0, pix[tap_ff]}));
      trial = {rem_ff[QB-1:0], num_ff[QB-1]};
      sq = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      st_in = st_ff; tap_in = tap_ff; acc_in = acc_ff; quo_in = quo_ff;
      rem_in = rem_ff; num_in = num_ff; dmag_in = dmag_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; res_in = res_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (start) begin
               st_in = ST_SUM; tap_in = '0; acc_in = '0;
            end
         end
         ST_SUM: begin
            acc_in = acc_ff + SUM_BITS'(prod);
            if (tap_ff == 4'd8) begin
               st_in = ST_DIV;
               num_in = (acc_in < 0) ? QB'(-acc_in) : QB'(acc_in);
               dmag_in = (dsx < 0) ? 16'(-dsx) : 16'(dsx);
               neg_in = (acc_in < 0) ^ (dsx < 0);
               rem_in = '0; quo_in = '0; cnt_in = '0;
            end else begin
               tap_in = tap_ff + 4'd1;
            end
         end
         ST_DIV: begin
            num_in = {num_ff[QB-2:0], 1'b0};
            if (trial >= (QB+1)'(dmag_ff)) begin
               rem_in = trial - (QB+1)'(dmag_ff);
               quo_in = {quo_ff[QB-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[QB-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CYC_BITS'(QB-1)) st_in = ST_OUT;
         end
         ST_OUT: begin
            if (sq < 0) res_in = '0;
            else if (sq > $signed((QB+1)'(PIX_MAX))) res_in = PIX_MAX;
            else res_in = sq[7:0];
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
      tap_ff <= tap_in; acc_ff <= acc_in; quo_ff <= quo_in; rem_ff <= rem_in;
      num_ff <= num_in; dmag_ff <= dmag_in; neg_ff <= neg_in; cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   assign done = (st_ff == ST_OUT);
   assign result = res_in;
endmodule

[src/r3cc_window.sv]
// Line stores, 3x3 window and raster position tracking.
// Uses r3cc_pkg.
`timescale 1ns / 1ps
module r3cc_window
   import r3cc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [PIX_BITS-1:0] pix,
   input  logic                pos_clear,
   input  logic [DIM_BITS-1:0] width_cfg,
   input  logic [DIM_BITS-1:0] height_cfg,
   output logic [PIX_BITS-1:0] win [9],
   output logic                interior,
   output logic [POS_BITS-1:0] cen_row,
   output logic [POS_BITS-1:0] cen_col,
   output logic                last,
   output logic                rd_ok
);
   logic [PIX_BITS-1:0] older_mem [MAX_WIDTH];
   logic [PIX_BITS-1:0] newer_mem [MAX_WIDTH];
   logic [PIX_BITS-1:0] win_ff [9];
   logic [DIM_BITS-1:0] row_ff, col_ff, w, h;
   logic [PIX_BITS-1:0] top_ff, mid_ff;
   logic [COL_BITS-1:0] ci;
   logic                rd_ok_ff;

   always_comb begin
      w = (width_cfg < 11'd3) ? 11'd3 :
          (width_cfg > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_cfg;
      h = (height_cfg < 11'd3) ? 11'd3 :
          (height_cfg > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : height_cfg;
      ci = col_ff[COL_BITS-1:0];
   end

   // line stores: read address is the column of the next pixel, data lands in the next cycle
   always_ff @(posedge clock) begin
      top_ff <= older_mem[ci];
      mid_ff <= newer_mem[ci];
      if (take) begin
         older_mem[ci] <= mid_ff;
         newer_mem[ci] <= pix;
      end
   end

   // read data is flagged good in the cycle after one with no take or position clear
   always_ff @(posedge clock) begin
      if (reset || take || pos_clear) rd_ok_ff <= 1'b0;
      else rd_ok_ff <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) win_ff[k] <= '0;
         interior <= 1'b0;
      end else if (take) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[3*k]   <= win_ff[3*k+1];
            win_ff[3*k+1] <= win_ff[3*k+2];
         end
         win_ff[2] <= top_ff; win_ff[5] <= mid_ff; win_ff[8] <= pix;
         interior <= row_ff >= 11'd2 && col_ff >= 11'd2;
         cen_row <= POS_BITS'(row_ff - 11'd1);
         cen_col <= POS_BITS'(col_ff - 11'd1);
         last <= (row_ff == h - 11'd1) && (col_ff == w - 11'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || pos_clear) begin
         row_ff <= '0; col_ff <= '0;
      end else if (take) begin
         if (col_ff + 11'd1 >= w) begin
            col_ff <= '0;
            row_ff <= (row_ff + 11'd1 >= h) ? '0 : row_ff + 11'd1;
         end else col_ff <= col_ff + 11'd1;
      end
   end

   assign win = win_ff;
   assign rd_ok = rd_ok_ff;
endmodule

[src/rgb_3x3_convolution_clamp.sv]
// Top level: RGB 3x3 convolution with divide and clamp.
// Depends on r3cc_pkg, r3cc_window, r3cc_lane.
`timescale 1ns / 1ps
// channel | dir | tdata fields (low bit up)                   | tuser
// req     | in  | in_red, in_green, in_blue                    | -
// rsp     | out | out_red, out_green, out_blue, out_row, out_col | frame_done
// csr     | in  | write enable, index, 48-bit data             | -
// A req transfer loads the window; the next cycle decides. A border pixel
// returns control to idle and frees req. An interior pixel starts the three
// lanes in parallel: a multiply-accumulate over the window, a restoring
// divide (one quotient bit a cycle) and a clamp; the result is then
// registered in the rsp register and req reopens with it. Synchronous
// active-high reset clears the window, position and control; line stores
// start undefined. A stalled rsp holds its register; border pixels keep
// flowing, and an interior pixel waits before starting the lanes until the
// rsp register is empty.
module rgb_3x3_convolution_clamp
   import r3cc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // in_red, in_green, in_blue
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_red, out_green, out_blue, out_row, out_col, pad
   output logic        rsp_tuser,   // frame_done
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);
   logic [47:0]         krow_ff [3];
   logic signed [15:0]  div_ff;
   logic [DIM_BITS-1:0] width_ff, height_ff;
   kernel_type          kern;
   logic                take, pos_clear, interior, last, rd_ok;
   logic [PIX_BITS-1:0] win [9];
   logic [POS_BITS-1:0] cen_row, cen_col;
   phase_type           phase_ff, phase_in;
   lane_ctl_type        ctl;
   logic [2:0]          done;
   logic [7:0]          res [3];
   logic [7:0]          chan [3][9];

   assign take = req_tvalid && req_tready;
   // line store read must have settled for the current column
   assign req_tready = (phase_ff == PH_IDLE) && rd_ok;
   assign pos_clear = csr_we && (csr_index == REG_WIDTH || csr_index == REG_HEIGHT);

   always_comb begin
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            kern[3*r+c] = coef_type'(krow_ff[r][16*c +: COEF_BITS]);
      for (int l = 0; l < 3; l++)
         for (int k = 0; k < 9; k++) chan[l][k] = win[k][8*l +: 8];
   end

   // control: lanes start only when the rsp register is free
   always_comb begin
      phase_in  = phase_ff;
      ctl.start = 1'b0;
      ctl.busy  = (phase_ff == PH_BUSY);
      unique case (phase_ff)
         PH_IDLE: if (take) phase_in = PH_LOAD;
         PH_LOAD: begin
            if (!interior) phase_in = PH_IDLE;
            else if (!rsp_tvalid) begin
               phase_in  = PH_BUSY;
               ctl.start = 1'b1;
            end
         end
         PH_BUSY: if (&done) phase_in = PH_IDLE;
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) phase_ff <= PH_IDLE;
      else phase_ff <= phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         krow_ff[0] <= '0; krow_ff[1] <= '0; krow_ff[2] <= '0;
         div_ff <= 16'sd1;
         width_ff <= 11'd1024; height_ff <= 11'd1024;
         rsp_tvalid <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_KTOP:   krow_ff[0] <= csr_wdata;
               REG_KMID:   krow_ff[1] <= csr_wdata;
               REG_KBOT:   krow_ff[2] <= csr_wdata;
               REG_DIV:    div_ff <= csr_wdata[15:0];
               REG_WIDTH:  width_ff <= csr_wdata[10:0];
               REG_HEIGHT: height_ff <= csr_wdata[10:0];
               default: ;
            endcase
         end
         if (ctl.busy && (&done)) begin
            rsp_tvalid <= 1'b1;
            rsp_tdata <= {4'd0, cen_col, cen_row, res[2], res[1], res[0]};
            rsp_tuser <= last;
         end else if (rsp_tvalid && rsp_tready) begin
            rsp_tvalid <= 1'b0;
         end
      end
   end

   r3cc_window u_window (
      .clock, .reset, .take, .pix(req_tdata), .pos_clear,
      .width_cfg(width_ff), .height_cfg(height_ff),
      .win, .interior, .cen_row, .cen_col, .last, .rd_ok
   );

   for (genvar l = 0; l < 3; l++) begin : g_lane
      r3cc_lane u_lane (
         .clock, .reset, .start(ctl.start), .pix(chan[l]), .kern,
         .divisor(div_ff), .done(done[l]), .result(res[l])
      );
   end
endmodule

[tb/sv/rgb_3x3_convolution_clamp_test.sv]
// Self-checking testbench for the RGB 3x3 convolution filter with divide and clamp.
// Depends on r3cc_pkg and rgb_3x3_convolution_clamp.
`timescale 1ns / 1ps
module rgb_3x3_convolution_clamp_test
   import r3cc_pkg::*;
();

   localparam int  SETTLE_CYCLES = 80;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int  ITEM_COUNT = 900;

   // one filtered pixel as it should leave the block
   typedef struct {
      logic [7:0] red, green, blue;
      logic [9:0] row, col;
      logic       done;
   } filtered_pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = REG_KTOP;
   logic [47:0] csr_wdata = '0;

   rgb_3x3_convolution_clamp DUT (.*);

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Filter model state: registers, line stores, window, raster position
   // ---------------------------------------------------------------------
   logic [47:0] kern_rows [3];
   logic [15:0] div_reg;
   logic [10:0] width_reg, height_reg;
   logic [23:0] line_older [MAX_WIDTH];
   logic [23:0] line_newer [MAX_WIDTH];
   logic [23:0] win [3][3];
   int unsigned cur_row, cur_col;

   logic [23:0]        pixel_q [$];     // pixels waiting for the driver
   filtered_pixel_type filtered_q [$];  // results the block still owes
   int     mismatches = 0;
   longint cycles = 0;

   function automatic int unsigned clamp_dim(logic [10:0] v, int unsigned maxv);
      if (v < 3) return 3;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // weighted sum of one channel, divided toward zero and clamped to a byte
   function automatic logic [7:0] filter_channel(int shift);
      longint acc, d;
      acc = 0;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            acc += longint'($signed(kern_rows[r][16*c +: 16]))
                   * longint'((win[r][c] >> shift) & 24'hFF);
      d = longint'($signed(div_reg));
      if (d == 0) d = 1;
      acc = acc / d;
      if (acc < 0) return 8'd0;
      if (acc > 255) return PIX_MAX;
      return acc[7:0];
   endfunction

   // advance the model by one accepted pixel, queueing any filtered result
   function automatic void absorb_pixel(logic [23:0] pix);
      int unsigned w, h, ci;
      filtered_pixel_type fp;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      ci = (cur_col < MAX_WIDTH) ? cur_col : MAX_WIDTH - 1;
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = line_older[ci];
      win[1][2] = line_newer[ci];
      win[2][2] = pix;
      line_older[ci] = line_newer[ci];
      line_newer[ci] = pix;
      if (cur_row >= 2 && cur_col >= 2 && cur_row < h && cur_col < w) begin
         fp.red   = filter_channel(0);
         fp.green = filter_channel(8);
         fp.blue  = filter_channel(16);
         fp.row   = 10'(cur_row - 1);
         fp.col   = 10'(cur_col - 1);
         fp.done  = (cur_row == h - 1 && cur_col == w - 1);
         filtered_q.push_back(fp);
      end
      cur_col++;
      if (cur_col >= w) begin
         cur_col = 0;
         cur_row++;
         if (cur_row >= h) cur_row = 0;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: bursts of transfers separated by random gaps
   // ---------------------------------------------------------------------
   logic req_took = 1'b0;   // set at the rising edge when a pixel transferred
   int   burst_left = 0, gap_left = 0;

   always @(negedge clock) begin
      logic       next_valid;
      logic [23:0] next_data;
      next_valid = req_tvalid;
      next_data  = req_tdata;
      if (!reset && (!req_tvalid || req_took)) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pixel_q.size() > 0) begin
            next_valid = 1'b1;
            next_data  = pixel_q.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            end
         end
      end
      req_tvalid <= next_valid;
      req_tdata  <= next_data;
   end

   // receiver: alternates between always-ready stretches and random stalls
   int stall_mode = 0, mode_left = 0;
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(20, 400);
      end
      mode_left--;
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 9) == 0);  // long stalls
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on input transfers, check result transfers
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      filtered_pixel_type exp_px;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
      req_took = !reset && req_tvalid && req_tready;
      if (req_took) absorb_pixel(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (filtered_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer: data=%h frame_done=%b",
                        rsp_tdata, rsp_tuser);
         end else begin
            exp_px = filtered_q.pop_front();
            if (rsp_tdata[7:0] !== exp_px.red || rsp_tdata[15:8] !== exp_px.green
                || rsp_tdata[23:16] !== exp_px.blue || rsp_tdata[33:24] !== exp_px.row
                || rsp_tdata[43:34] !== exp_px.col || rsp_tuser !== exp_px.done) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp rgb=%h,%h,%h row=%0d col=%0d done=%b, ",
                            "got rgb=%h,%h,%h row=%0d col=%0d done=%b"},
                           exp_px.red, exp_px.green, exp_px.blue, exp_px.row, exp_px.col,
                           exp_px.done, rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16],
                           rsp_tdata[33:24], rsp_tdata[43:34], rsp_tuser);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // wait until the pipe has drained, then give the divider time to finish
   task automatic wait_drained();
      do @(negedge clock);
      while (pixel_q.size() != 0 || req_tvalid || filtered_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(reg_idx_type idx, logic [47:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx) inside
         REG_KTOP, REG_KMID, REG_KBOT: kern_rows[idx] = value;
         REG_DIV: div_reg = value[15:0];
         REG_WIDTH: begin
            width_reg = value[10:0];
            cur_row = 0;
            cur_col = 0;
         end
         REG_HEIGHT: begin
            height_reg = value[10:0];
            cur_row = 0;
            cur_col = 0;
         end
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] random_coef();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2, 3: return 16'($signed($urandom_range(0, 8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_divisor();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'h8000;
         2: return 16'h7FFF;
         3: return 16'hFFFF;
         4: return 16'($urandom);
         default: return 16'($urandom_range(1, 20));
      endcase
   endfunction

   task automatic load_kernel(logic [15:0] c [9], logic [15:0] dv);
      write_reg(REG_KTOP, {c[2], c[1], c[0]});
      write_reg(REG_KMID, {c[5], c[4], c[3]});
      write_reg(REG_KBOT, {c[8], c[7], c[6]});
      write_reg(REG_DIV, {32'h0, dv});
   endtask

   task automatic random_kernel();
      logic [15:0] c [9];
      foreach (c[i]) c[i] = random_coef();
      load_kernel(c, random_divisor());
   endtask

   function automatic logic [23:0] random_pixel();
      case ($urandom_range(0, 7))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   // queue up to n pixels, never past the item budget
   task automatic queue_pixels(int n, ref int sent);
      int count;
      count = (sent + n > ITEM_COUNT) ? ITEM_COUNT - sent : n;
      if (count < 0) count = 0;
      repeat (count) pixel_q.push_back(random_pixel());
      sent += count;
   endtask

   task automatic set_dims(logic [10:0] w, logic [10:0] h);
      write_reg(REG_WIDTH, {37'h0, w});
      write_reg(REG_HEIGHT, {37'h0, h});
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [15:0] k [9];
      int sent;
      int w, h;
      sent = 0;
      kern_rows = '{default: '0};
      div_reg = 16'd1;
      width_reg = 11'd1024;
      height_reg = 11'd1024;
      foreach (line_older[i]) begin
         line_older[i] = '0;
         line_newer[i] = '0;
      end
      win = '{default: '0};
      cur_row = 0;
      cur_col = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: 3x3 frames with identity, max-positive and max-negative kernels
      set_dims(11'd3, 11'd3);
      k = '{default: 16'h0};
      k[4] = 16'h0001;
      load_kernel(k, 16'd0);                  // zero divisor acts as one
      repeat (4) pixel_q.push_back(24'h000000);
      pixel_q.push_back(24'hFFFFFF);          // center pixel, all ones
      repeat (4) pixel_q.push_back(24'hFF00FF);
      wait_drained();
      k = '{default: 16'h7FFF};
      load_kernel(k, 16'h7FFF);
      repeat (9) pixel_q.push_back(24'hFFFFFF);
      wait_drained();
      k = '{default: 16'h8000};
      load_kernel(k, 16'h8000);               // negative over negative
      repeat (9) pixel_q.push_back(24'hFF80FF);
      sent = 27;
      wait_drained();

      // tall narrow frame
      random_kernel();
      set_dims(11'd3, 11'd40);
      queue_pixels(3 * 40, sent);
      wait_drained();

      // random frames
      while (sent < ITEM_COUNT) begin
         case ($urandom_range(0, 9))
            0: begin
               // out-of-range sizes clamp to the legal range; the widest
               // setting only gets part of its first row
               random_kernel();
               w = $urandom_range(0, 1) ? $urandom_range(0, 2) : 2047;
               h = $urandom_range(0, 2);
               set_dims(11'(w), 11'(h));
               queue_pixels((w > 1024) ? 60 : 9, sent);
            end
            1: begin
               // coefficients change mid-frame while the block is idle
               random_kernel();
               queue_pixels($urandom_range(1, 30), sent);
            end
            default: begin
               random_kernel();
               w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(3, 8);
               h = $urandom_range(3, 8);
               set_dims(11'(w), 11'(h));
               queue_pixels(w * h * $urandom_range(1, 2), sent);
            end
         endcase
         wait_drained();
      end

      wait_drained();
      if (mismatches == 0 && filtered_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
